>>> rtl/mktd_pkg.sv
package mktd_pkg;

    localparam int PIN_KEYS        = 2;
    localparam int EVENTS_PER_POLL = 2;
    localparam int EVQ_DEPTH       = 4;
    localparam int EVQ_AW          = 2;

    localparam logic [1:0] REG_PRESS_LEVEL   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_TIME = 2'd1;
    localparam logic [1:0] REG_KEY_ENABLE    = 2'd2;
    localparam logic [1:0] REG_EVENT_LIMIT   = 2'd3;

    localparam logic [1:0] EVENT_LIMIT_MAX = 2'd2;

    typedef struct packed {
        logic        key_index;
        logic        pressed;
        logic [31:0] event_time;
        logic        last;
    } event_t;

    typedef struct packed {
        logic hit;
        logic raw;
    } lane_stat_t;

endpackage

>>> rtl/mktd_lane.sv
module mktd_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enabled,
    input  logic                 level,
    input  logic                 press_level,
    input  logic [31:0]          now_ms,
    input  logic [31:0]          debounce_time,
    input  logic                 load,
    input  logic                 commit,
    output mktd_pkg::lane_stat_t stat
);
    import mktd_pkg::*;

    logic        raw_seen_reg;
    logic        raw_seen_next;
    logic        stable_reg;
    logic        stable_next;
    logic [31:0] change_time_reg;
    logic [31:0] change_time_next;
    logic        raw;
    logic        changed;
    logic [31:0] elapsed;

    assign raw     = (level == press_level);
    assign changed = (raw != raw_seen_reg);
    assign elapsed = now_ms - change_time_reg;

    assign stat.raw = raw;
    assign stat.hit = enabled && !changed && (raw != stable_reg) && (elapsed >= debounce_time);

    always_comb
    begin
        raw_seen_next    = raw_seen_reg;
        stable_next      = stable_reg;
        change_time_next = change_time_reg;
        if (load)
        begin
            raw_seen_next    = raw;
            stable_next      = raw;
            change_time_next = now_ms;
        end
        else if (commit && enabled)
        begin
            if (changed)
            begin
                raw_seen_next    = raw;
                change_time_next = now_ms;
            end
            else if (stat.hit)
            begin
                stable_next = raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_seen_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
        end
        else
        begin
            raw_seen_reg    <= raw_seen_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

>>> rtl/mktd_merge.sv
module mktd_merge #(
    parameter int NUM_KEYS = 2
) (
    input  mktd_pkg::lane_stat_t [NUM_KEYS-1:0]                 stat,
    input  logic [1:0]                                          limit,
    input  logic [31:0]                                         now_ms,
    output logic [NUM_KEYS-1:0]                                 examine,
    output mktd_pkg::event_t [mktd_pkg::EVENTS_PER_POLL-1:0]    events,
    output logic [1:0]                                          num_events
);
    import mktd_pkg::*;

    logic [1:0] cnt;

    always_comb
    begin
        cnt    = '0;
        events = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            examine[k] = (cnt < limit);
            if (examine[k] && stat[k].hit)
            begin
                events[cnt[0]].key_index  = 1'(k);
                events[cnt[0]].pressed    = stat[k].raw;
                events[cnt[0]].event_time = now_ms;
                cnt = cnt + 2'd1;
            end
        end
        if (cnt == 2'd1)
        begin
            events[0].last = 1'b1;
        end
        else if (cnt == 2'd2)
        begin
            events[1].last = 1'b1;
        end
        num_events = cnt;
    end

endmodule

>>> rtl/mktd_evq.sv
module mktd_evq (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  mktd_pkg::event_t [mktd_pkg::EVENTS_PER_POLL-1:0]   push_events,
    input  logic [1:0]                                         push_num,
    output logic                                               full,
    output logic                                               out_valid,
    input  logic                                               out_stall,
    output mktd_pkg::event_t                                   head
);
    import mktd_pkg::*;

    event_t                  mem_reg [EVQ_DEPTH];
    logic [EVQ_AW-1:0]       wr_ptr_reg;
    logic [EVQ_AW-1:0]       wr_ptr_next;
    logic [EVQ_AW-1:0]       rd_ptr_reg;
    logic [EVQ_AW-1:0]       rd_ptr_next;
    logic [EVQ_AW:0]         count_reg;
    logic [EVQ_AW:0]         count_next;
    logic                    pop;

    assign out_valid = (count_reg != '0);
    assign full      = (count_reg > (EVQ_AW+1)'(EVQ_DEPTH - EVENTS_PER_POLL));
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + EVQ_AW'(push_num);
        rd_ptr_next = rd_ptr_reg + EVQ_AW'(pop);
        count_next  = count_reg + (EVQ_AW+1)'(push_num) - (EVQ_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_events[0];
        end
        if (push_num == 2'd2)
        begin
            mem_reg[wr_ptr_reg + EVQ_AW'(1)] <= push_events[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/multi_key_time_debouncer.sv
// Events enter the event queue as their poll transfers and leave from its head.
// One poll per cycle is accepted unless the event queue holds three or more
// events; a poll may push two events while the output pops one at a time.
// Reset (rst_n, async, active low) clears key state, empties the event queue,
// and restores register defaults; the first poll afterwards only loads key state.
module multi_key_time_debouncer #(
    parameter int NUM_KEYS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  raw_levels,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        key_index,
    output logic        pressed,
    output logic [31:0] event_time,
    output logic        last
);
    import mktd_pkg::*;

    logic                                press_level_reg;
    logic [31:0]                         debounce_time_reg;
    logic [1:0]                          key_enable_reg;
    logic [1:0]                          event_limit_reg;
    logic                                primed_reg;
    logic                                in_xfer;
    logic                                q_full;
    logic [1:0]                          limit;
    lane_stat_t [NUM_KEYS-1:0]           stat;
    logic [NUM_KEYS-1:0]                 examine;
    event_t [EVENTS_PER_POLL-1:0]        events;
    logic [1:0]                          num_events;
    logic [1:0]                          push_num;
    event_t                              head;

    assign in_stall = q_full;
    assign in_xfer  = in_valid && !in_stall;
    assign limit    = (event_limit_reg > EVENT_LIMIT_MAX) ? EVENT_LIMIT_MAX : event_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_level_reg   <= 1'b0;
            debounce_time_reg <= 32'd20;
            key_enable_reg    <= 2'd3;
            event_limit_reg   <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESS_LEVEL:   press_level_reg   <= cfg_data[0];
                REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data;
                REG_KEY_ENABLE:    key_enable_reg    <= cfg_data[1:0];
                REG_EVENT_LIMIT:   event_limit_reg   <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            primed_reg <= 1'b1;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic lane_level;
        logic lane_en;

        if (k < PIN_KEYS)
        begin : g_pin
            assign lane_level = raw_levels[k];
            assign lane_en    = key_enable_reg[k];
        end
        else
        begin : g_nopin
            assign lane_level = 1'b0;
            assign lane_en    = 1'b0;
        end

        mktd_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .enabled       (lane_en),
            .level         (lane_level),
            .press_level   (press_level_reg),
            .now_ms        (now_ms),
            .debounce_time (debounce_time_reg),
            .load          (in_xfer && !primed_reg),
            .commit        (in_xfer && primed_reg && examine[k]),
            .stat          (stat[k])
        );
    end

    mktd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .stat       (stat),
        .limit      (limit),
        .now_ms     (now_ms),
        .examine    (examine),
        .events     (events),
        .num_events (num_events)
    );

    assign push_num = (in_xfer && primed_reg) ? num_events : 2'd0;

    mktd_evq u_evq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_events (events),
        .push_num    (push_num),
        .full        (q_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .head        (head)
    );

    assign key_index  = head.key_index;
    assign pressed    = head.pressed;
    assign event_time = head.event_time;
    assign last       = head.last;

endmodule

>>> sim/tb_multi_key_time_debouncer.sv
module tb_multi_key_time_debouncer;

    import mktd_pkg::*;

    localparam int TAIL_ITEMS    = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 200;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_POLLS  = 1700;

    typedef enum logic [1:0] {PLAN_POLL, PLAN_WRITE, PLAN_DRAIN, PLAN_HOLD} plan_kind_e;

    typedef struct {
        plan_kind_e  kind;
        logic [1:0]  levels;
        logic [31:0] stamp;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
    } plan_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = REG_PRESS_LEVEL;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  raw_levels = '0;
    logic [31:0] now_ms     = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        key_index;
    logic        pressed;
    logic [31:0] event_time;
    logic        last;

    plan_t  poll_plan[$];
    event_t expected_events[$];

    // register shadow
    logic        cur_active   = 1'b0;
    logic [31:0] cur_debounce = 32'd20;
    logic [1:0]  cur_enable   = 2'd3;
    logic [1:0]  cur_limit    = 2'd2;

    // key state shadow
    logic [PIN_KEYS-1:0] seen_raw        = '0;
    logic [PIN_KEYS-1:0] debounced_state = '0;
    logic [31:0]         last_change_ms  [PIN_KEYS];
    logic                armed           = 1'b0;

    int plan_limit         = 2;
    int plan_mask          = 3;
    int gap_left           = 0;
    int settle_cnt         = 0;
    int send_gap_pct       = 0;
    int pace_cnt           = 0;
    int holds_asked        = 0;
    int holds_served       = 0;
    int stall_left         = 0;
    int stall_pct          = 0;
    int stall_pace         = 0;
    int cycles             = 0;
    int mismatch_count     = 0;
    int events_checked     = 0;
    int polls_sent         = 0;
    int writes_done        = 0;
    int backpressure_cycles = 0;

    multi_key_time_debouncer #(
        .NUM_KEYS(PIN_KEYS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_levels(raw_levels),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_index (key_index),
        .pressed   (pressed),
        .event_time(event_time),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void debounce_poll(input logic [1:0] levels, input logic [31:0] stamp);
        int unsigned budget;
        int unsigned emitted;
        logic        now_pressed;
        logic [31:0] held_ms;
        event_t      ev;
        if (!armed)
        begin
            for (int k = 0; k < PIN_KEYS; k++)
            begin
                seen_raw[k]        = (levels[k] == cur_active);
                debounced_state[k] = seen_raw[k];
                last_change_ms[k]  = stamp;
            end
            armed = 1'b1;
            return;
        end
        budget  = (cur_limit > EVENT_LIMIT_MAX) ? EVENT_LIMIT_MAX : cur_limit;
        emitted = 0;
        for (int k = 0; k < PIN_KEYS && emitted < budget; k++)
        begin
            if (!cur_enable[k])
                continue;
            now_pressed = (levels[k] == cur_active);
            if (now_pressed != seen_raw[k])
            begin
                seen_raw[k]       = now_pressed;
                last_change_ms[k] = stamp;
                continue;
            end
            held_ms = stamp - last_change_ms[k];
            if (now_pressed != debounced_state[k] && held_ms >= cur_debounce)
            begin
                debounced_state[k] = now_pressed;
                ev.key_index  = (k != 0);
                ev.pressed    = now_pressed;
                ev.event_time = stamp;
                ev.last       = 1'b0;
                expected_events.push_back(ev);
                emitted++;
            end
        end
        if (emitted > 0)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endfunction

    task automatic add_poll(input logic [1:0] levels, input logic [31:0] stamp);
        plan_t p;
        p.kind    = PLAN_POLL;
        p.levels  = levels;
        p.stamp   = stamp;
        p.reg_idx = REG_PRESS_LEVEL;
        p.reg_val = '0;
        poll_plan.push_back(p);
    endtask

    task automatic add_action(input plan_kind_e kind, input logic [1:0] idx,
                              input logic [31:0] val);
        plan_t p;
        p.kind    = kind;
        p.levels  = '0;
        p.stamp   = '0;
        p.reg_idx = idx;
        p.reg_val = val;
        if (kind == PLAN_WRITE && idx == REG_KEY_ENABLE)
            plan_mask = val[1:0];
        if (kind == PLAN_WRITE && idx == REG_EVENT_LIMIT)
            plan_limit = val[1:0];
        poll_plan.push_back(p);
    endtask

    // driver: polls and register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            raw_levels <= '0;
            now_ms     <= '0;
            cfg_we     <= 1'b0;
            cfg_index  <= REG_PRESS_LEVEL;
            cfg_data   <= '0;
        end
        else
        begin : feed
            plan_t head;
            logic  v_n;
            logic  we_n;
            v_n  = 1'b0;
            we_n = 1'b0;
            if (!in_valid && !out_valid && expected_events.size() == 0)
            begin
                if (settle_cnt < 1000)
                    settle_cnt++;
            end
            else
                settle_cnt = 0;
            if (pace_cnt == 0)
            begin
                pace_cnt = 150;
                case ($urandom_range(0, 3))
                    0, 1:    send_gap_pct = 0;
                    2:       send_gap_pct = 10;
                    default: send_gap_pct = 40;
                endcase
            end
            pace_cnt--;
            if (in_valid && in_stall)
                v_n = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (poll_plan.size() != 0)
            begin
                head = poll_plan[0];
                case (head.kind)
                    PLAN_POLL:
                        if (poll_plan.size() > TAIL_ITEMS && $urandom_range(0, 99) < send_gap_pct)
                            gap_left = $urandom_range(0, 18);
                        else
                        begin
                            v_n = 1'b1;
                            raw_levels <= head.levels;
                            now_ms     <= head.stamp;
                            void'(poll_plan.pop_front());
                        end
                    PLAN_WRITE:
                        if (settle_cnt >= SETTLE_CYCLES)
                        begin
                            we_n = 1'b1;
                            cfg_index <= head.reg_idx;
                            cfg_data  <= head.reg_val;
                            case (head.reg_idx)
                                REG_PRESS_LEVEL:   cur_active   = head.reg_val[0];
                                REG_DEBOUNCE_TIME: cur_debounce = head.reg_val;
                                REG_KEY_ENABLE:    cur_enable   = head.reg_val[1:0];
                                REG_EVENT_LIMIT:   cur_limit    = head.reg_val[1:0];
                                default:           ;
                            endcase
                            writes_done++;
                            void'(poll_plan.pop_front());
                        end
                    PLAN_DRAIN:
                        if (settle_cnt >= SETTLE_CYCLES)
                            void'(poll_plan.pop_front());
                    PLAN_HOLD:
                    begin
                        holds_asked++;
                        void'(poll_plan.pop_front());
                    end
                endcase
            end
            in_valid <= v_n;
            cfg_we   <= we_n;
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin : hold_off
            logic s_n;
            s_n = 1'b0;
            if (stall_pace == 0)
            begin
                stall_pace = 130;
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 5;
                    2:       stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            stall_pace--;
            if (holds_served != holds_asked)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                s_n = 1'b1;
            end
            else if (poll_plan.size() > TAIL_ITEMS && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 18);
                s_n = 1'b1;
            end
            out_stall <= s_n;
        end
    end

    // monitor: predict on each poll transfer, check each event transfer
    always @(posedge clk)
    begin : watch
        event_t got;
        event_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                debounce_poll(raw_levels, now_ms);
                polls_sent++;
            end
            if (in_valid && in_stall)
                backpressure_cycles++;
            if (out_valid && !out_stall)
            begin
                got = {key_index, pressed, event_time, last};
                events_checked++;
                if (expected_events.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected event: key %0d pressed %0b time %0d last %0b",
                                 got.key_index, got.pressed, got.event_time, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got.key_index !== want.key_index || got.pressed !== want.pressed ||
                        got.event_time !== want.event_time || got.last !== want.last)
                    begin
                        if (mismatch_count < 10)
                            $display({"event mismatch: expected key %0d pressed %0b time %0d ",
                                      "last %0b, got key %0d pressed %0b time %0d last %0b"},
                                     want.key_index, want.pressed, want.event_time, want.last,
                                     got.key_index, got.pressed, got.event_time, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycles, expected_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]  target;
        logic [1:0]  lv;
        logic [31:0] clock_ms;
        logic [31:0] deb;
        int          random_polls;
        int          phase_len;
        int          step_max;
        int          pick;
        bit          noisy;

        // directed: priming, debounce edges, enable mask and event limit cases
        add_poll(2'b10, 32'd0);
        add_poll(2'b01, 32'd5);
        add_poll(2'b01, 32'd24);
        add_poll(2'b01, 32'd25);
        add_action(PLAN_WRITE, REG_PRESS_LEVEL, 32'd1);
        add_action(PLAN_WRITE, REG_DEBOUNCE_TIME, 32'hFFFF_FFFF);
        add_poll(2'b11, 32'd1000);
        add_poll(2'b11, 32'd999);
        add_poll(2'b11, 32'hFFFF_FFFF);
        add_action(PLAN_WRITE, REG_DEBOUNCE_TIME, 32'd0);
        add_action(PLAN_WRITE, REG_KEY_ENABLE, 32'd1);
        add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd1);
        add_poll(2'b00, 32'hFFFF_FFFF);
        add_poll(2'b00, 32'd0);
        add_action(PLAN_WRITE, REG_KEY_ENABLE, 32'd2);
        add_poll(2'b00, 32'd7);
        add_poll(2'b00, 32'd7);
        add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd0);
        add_action(PLAN_WRITE, REG_KEY_ENABLE, 32'd3);
        add_poll(2'b11, 32'd8);
        add_poll(2'b11, 32'd9);
        add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd3);
        add_poll(2'b11, 32'd10);
        add_poll(2'b11, 32'd11);
        add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd1);
        add_poll(2'b00, 32'd12);
        add_poll(2'b00, 32'd13);
        add_poll(2'b00, 32'd14);

        // fill the event queue under a long receiver hold
        add_action(PLAN_WRITE, REG_PRESS_LEVEL, 32'd0);
        add_action(PLAN_WRITE, REG_DEBOUNCE_TIME, 32'd0);
        add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd2);
        add_action(PLAN_HOLD, REG_PRESS_LEVEL, 32'd0);
        clock_ms = 32'd100;
        for (int i = 0; i < 60; i++)
        begin
            clock_ms += 1;
            add_poll((i % 4 < 2) ? 2'b00 : 2'b11, clock_ms);
        end
        add_action(PLAN_DRAIN, REG_PRESS_LEVEL, 32'd0);

        random_polls = 0;
        while (random_polls < RANDOM_POLLS)
        begin
            if ($urandom_range(0, 99) < 50)
                add_action(PLAN_WRITE, REG_PRESS_LEVEL, $urandom_range(0, 1));
            if ($urandom_range(0, 99) < 60)
            begin
                case ($urandom_range(0, 9))
                    0:       deb = 32'd0;
                    1:       deb = 32'd1;
                    2:       deb = 32'hFFFF_FFFF;
                    3:       deb = $urandom();
                    default: deb = $urandom_range(2, 40);
                endcase
                add_action(PLAN_WRITE, REG_DEBOUNCE_TIME, deb);
            end
            if ($urandom_range(0, 99) < 40)
            begin
                pick = $urandom_range(0, 5);
                add_action(PLAN_WRITE, REG_KEY_ENABLE, (pick > 2) ? 32'd3 : pick);
            end
            if ($urandom_range(0, 99) < 40)
            begin
                case ($urandom_range(0, 5))
                    0:       add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd0);
                    1:       add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd1);
                    2:       add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd3);
                    default: add_action(PLAN_WRITE, REG_EVENT_LIMIT, 32'd2);
                endcase
            end
            noisy     = ($urandom_range(0, 99) < 20);
            phase_len = $urandom_range(40, 120);
            step_max  = $urandom_range(1, 10);
            target    = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0:       clock_ms = $urandom();
                1:       clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
                default: clock_ms = $urandom_range(0, 1000);
            endcase
            for (int i = 0; i < phase_len; i++)
            begin
                if (noisy)
                begin
                    lv       = 2'($urandom_range(0, 3));
                    clock_ms = $urandom();
                end
                else
                begin
                    clock_ms += $urandom_range(0, step_max);
                    if ($urandom_range(0, 99) < 3)
                        clock_ms = $urandom();
                    for (int k = 0; k < PIN_KEYS; k++)
                        if ($urandom_range(0, 99) < 8)
                            target[k] = ~target[k];
                    lv = target;
                    for (int k = 0; k < PIN_KEYS; k++)
                        if ($urandom_range(0, 99) < 12)
                            lv[k] = ~lv[k];
                end
                add_poll(lv, clock_ms);
                random_polls++;
                if ($urandom_range(0, 99) < 2)
                    add_action(PLAN_DRAIN, REG_PRESS_LEVEL, 32'd0);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (poll_plan.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 5) @(posedge clk);
        mismatch_count += expected_events.size();

        $display("Ran %0d polls through %0d register writes; %0d key events checked",
                 polls_sent, writes_done, events_checked);
        $display("Poll input held off by a full event queue for %0d cycles, %0d mismatches",
                 backpressure_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> multi_key_time_debouncer.f
rtl/mktd_pkg.sv
rtl/mktd_lane.sv
rtl/mktd_merge.sv
rtl/mktd_evq.sv
rtl/multi_key_time_debouncer.sv
sim/tb_multi_key_time_debouncer.sv
